// ===== src/mtf_pkg.sv =====
// Shared types and constants for the move-to-front list.
package mtf_pkg;

  // Width of one list entry and of the narrow position and count fields.
  localparam int DATA_W  = 32;
  localparam int FIELD_W = 7;

  // Request kinds as they arrive on the request channel.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_SEARCH = 2'd3
  } req_kind_t;

  // What every cell does with its entry in the shift cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_MTF
  } cell_op_t;

  // Control broadcast from the sequencer to the row of cells.
  typedef struct packed {
    logic                cmp;
    cell_op_t            op;
    logic [DATA_W-1:0]   key;
  } cell_ctl_t;

endpackage

// ===== src/mtf_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
interface mtf_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [mtf_pkg::FIELD_W-1:0]       position;
  logic signed [mtf_pkg::DATA_W-1:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink (input valid, input req_type, input position, input value,
                output ready);
endinterface

// ===== src/mtf_resp_if.sv =====
// Response channel: valid/ready handshake with the result fields.
interface mtf_resp_if;
  logic                              valid;
  logic                              ready;
  logic [mtf_pkg::FIELD_W-1:0]       found_position;
  logic signed [mtf_pkg::DATA_W-1:0] read_value;
  logic [mtf_pkg::FIELD_W-1:0]       entry_count;
  logic                              error;

  modport source (output valid, output found_position, output read_value,
                  output entry_count, output error, input ready);
  modport sink (input valid, input found_position, input read_value,
                input entry_count, input error, output ready);
endinterface

// ===== src/mtf_cell.sv =====
// One list slot: holds an entry, compares it, and shifts with its neighbors.
module mtf_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int POS_W = 8
) (
  input  logic                        clk,
  input  mtf_pkg::cell_ctl_t          ctl,
  input  logic [CNT_W-1:0]            count,
  input  logic [POS_W-1:0]            pos,
  input  logic [mtf_pkg::DATA_W-1:0]  left,
  input  logic [mtf_pkg::DATA_W-1:0]  right,
  input  logic                        le_bit,
  output logic [mtf_pkg::DATA_W-1:0]  data,
  output logic                        at_pos,
  output logic                        match
);
  import mtf_pkg::*;

  // 1-based position of this slot and its 0-based index.
  localparam logic [POS_W-1:0] NUM  = POS_W'(IDX + 1);
  localparam logic [POS_W-1:0] SLOT = POS_W'(IDX);

  logic after_pos;

  // Compare cycle: latch the position decode and the key match.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      at_pos    <= (pos == NUM);
      after_pos <= (pos < NUM);
      match     <= (SLOT < POS_W'(count)) && (data == ctl.key);
    end
  end

  // Shift cycle: take the key, a neighbor's entry, or hold.
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INS: begin
        if (at_pos) begin
          data <= ctl.key;
        end else if (after_pos) begin
          data <= left;
        end
      end
      CELL_REM: begin
        if (at_pos || after_pos) begin
          data <= right;
        end
      end
      CELL_MTF: begin
        if (le_bit) begin
          data <= left;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// ===== src/move_to_front_list.sv =====
// Move-to-front list: a row of entry cells with the request sequencer.
//
// Holds an ordered list of up to MAX_ENTRIES signed 32-bit values, one value
// per cell. Each request passes through a compare state and then a shift state
// after its transfer: in the compare state all cells compare their entry
// against the key and decode the position in parallel, in the shift state all
// cells shift together and the result is registered on the response channel.
// The next request is taken in the shift state, while the last one is shifted;
// the response register stalls the shift state while an earlier result has
// not yet been taken. Insert, remove and a search hit move entries by one
// cell; a search hit is moved to the front. A refused request (bad position,
// or an insert into a full list) sets error and leaves the list unchanged.
module move_to_front_list #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  mtf_req_if.sink     req,
  mtf_resp_if.source  resp
);
  import mtf_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int POS_W = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  state_t              state;
  req_kind_t           kind;
  logic [POS_W-1:0]    pos;
  logic [DATA_W-1:0]   key;
  logic [CNT_W-1:0]    count;
  logic                err;

  logic                err_next;
  logic [CNT_W-1:0]    count_next;
  logic                out_free;
  logic                apply_go;
  logic                hit;
  logic [MAX_ENTRIES-1:0] le_mask;
  logic [MAX_ENTRIES-1:0] first_hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [POS_W-1:0]    hit_pos;
  logic [DATA_W-1:0]   rd_data;
  cell_ctl_t           ctl;

  logic [DATA_W-1:0]      cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_at;
  logic [MAX_ENTRIES-1:0] cell_match;

  // Handshake: a new request may enter while idle or in the shift cycle.
  assign out_free  = !resp.valid || resp.ready;
  assign apply_go  = (state == ST_APPLY) && out_free;
  assign req.ready = (state == ST_IDLE) || apply_go;

  // Refusal check, done in the compare cycle.
  always_comb begin
    case (kind)
      REQ_INSERT: err_next = (count == CNT_W'(MAX_ENTRIES)) || (pos == '0) ||
                             (pos > POS_W'(count) + POS_W'(1));
      REQ_READ,
      REQ_REMOVE: err_next = (pos == '0) || (pos > POS_W'(count));
      default:    err_next = 1'b0;
    endcase
  end

  // First match: the lowest set match bit, and the mask of cells up to it.
  always_comb begin
    hit       = |cell_match;
    le_mask   = cell_match ^ (cell_match - MAX_ENTRIES'(1));
    first_hit = cell_match & ~(cell_match - MAX_ENTRIES'(1));
    hit_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    hit_pos = POS_W'(hit_idx) + POS_W'(1);
  end

  // Read port: the one cell at the requested position drives the data.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_data = rd_data | (cell_at[i] ? cell_data[i] : '0);
    end
  end

  // Entry count after the request.
  always_comb begin
    count_next = count;
    if (!err) begin
      case (kind)
        REQ_INSERT: count_next = count + CNT_W'(1);
        REQ_REMOVE: count_next = count - CNT_W'(1);
        default:    count_next = count;
      endcase
    end
  end

  // Broadcast to the cells.
  always_comb begin
    ctl.cmp = (state == ST_CMP);
    ctl.key = key;
    ctl.op  = CELL_HOLD;
    if (apply_go && !err) begin
      case (kind)
        REQ_INSERT: ctl.op = CELL_INS;
        REQ_REMOVE: ctl.op = CELL_REM;
        REQ_SEARCH: ctl.op = hit ? CELL_MTF : CELL_HOLD;
        default:    ctl.op = CELL_HOLD;
      endcase
    end
  end

  // Row of cells; the front cell takes the key from its left side.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (g == 0) begin : g_front
      assign left_data = key;
    end else begin : g_mid
      assign left_data = cell_data[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_back
      assign right_data = cell_data[g];
    end else begin : g_inner
      assign right_data = cell_data[g+1];
    end

    mtf_cell #(
      .IDX   (g),
      .CNT_W (CNT_W),
      .POS_W (POS_W)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .count  (count),
      .pos    (pos),
      .left   (left_data),
      .right  (right_data),
      .le_bit (le_mask[g]),
      .data   (cell_data[g]),
      .at_pos (cell_at[g]),
      .match  (cell_match[g])
    );
  end

  // Sequencer, request registers and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      resp.valid <= 1'b0;
    end else begin
      // Drop a taken response unless the shift cycle replaces it.
      if (resp.valid && resp.ready && !apply_go) begin
        resp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            kind  <= req_kind_t'(req.req_type);
            pos   <= POS_W'(req.position);
            key   <= req.value;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          err   <= err_next;
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (out_free) begin
            resp.valid          <= 1'b1;
            resp.error          <= err;
            resp.entry_count    <= FIELD_W'(POS_W'(count_next));
            resp.found_position <= (kind == REQ_SEARCH && hit) ?
                                   hit_pos[FIELD_W-1:0] : '0;
            resp.read_value     <= (kind == REQ_READ && !err) ? rd_data : '0;
            count               <= count_next;
            if (req.valid) begin
              kind  <= req_kind_t'(req.req_type);
              pos   <= POS_W'(req.position);
              key   <= req.value;
              state <= ST_CMP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The list never holds more entries than there are cells.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    POS_W'(count) <= POS_W'(MAX_ENTRIES))
    else $error("entry count exceeds capacity");

  // A response only appears out of the shift cycle.
  a_resp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(resp.valid) |-> $past(state == ST_APPLY))
    else $error("response raised outside the shift cycle");

  // An accepted insert grows the list by exactly one entry.
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (apply_go && kind == REQ_INSERT && !err) |=>
      count == $past(count) + CNT_W'(1))
    else $error("insert did not advance the entry count");

  // At most one cell decodes the requested position.
  a_pos_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> $onehot0(cell_at))
    else $error("several cells selected by one position");
`endif

endmodule

// ===== tb/mtf_list_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks move-to-front list responses.
package mtf_list_scoreboard_pkg;
  import mtf_pkg::*;

  // Capacity of the list instance under test.
  localparam int LIST_DEPTH = 64;

  // One response as it appears on the response channel.
  typedef struct packed {
    logic [FIELD_W-1:0] found_position;
    logic [DATA_W-1:0]  read_value;
    logic [FIELD_W-1:0] entry_count;
    logic               error;
  } list_result_t;

  class mtf_list_scoreboard;
    // Predicted list contents, front of the list at index 0.
    logic [DATA_W-1:0] list_vals[$];
    // Predicted responses that have not yet been seen.
    list_result_t      expected_q[$];
    int unsigned       mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned list_len();
      return list_vals.size();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the predicted list and queue its response.
    function void note_request(req_kind_t kind, logic [FIELD_W-1:0] pos,
                               logic [DATA_W-1:0] val);
      list_result_t r;
      int unsigned  n;
      int           hit;
      n   = list_vals.size();
      r   = '0;
      hit = -1;
      case (kind)
        REQ_INSERT: begin
          if (n >= LIST_DEPTH || pos == 0 || pos > n + 1) r.error = 1'b1;
          else list_vals.insert(pos - 1, val);
        end
        REQ_READ: begin
          if (pos == 0 || pos > n) r.error = 1'b1;
          else r.read_value = list_vals[pos - 1];
        end
        REQ_REMOVE: begin
          if (pos == 0 || pos > n) r.error = 1'b1;
          else list_vals.delete(pos - 1);
        end
        default: begin
          // The first match wins; a hit behind the front moves to the front.
          for (int i = 0; i < n; i++) begin
            if (hit < 0 && list_vals[i] == val) hit = i;
          end
          if (hit >= 0) begin
            r.found_position = FIELD_W'(hit + 1);
            if (hit > 0) begin
              list_vals.delete(hit);
              list_vals.push_front(val);
            end
          end
        end
      endcase
      r.entry_count = FIELD_W'(list_vals.size());
      expected_q.push_back(r);
    endfunction

    // Compare one response transfer with the oldest prediction.
    function void check_result(list_result_t got);
      list_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: response with no request outstanding: %s %0d %0h %0d %0b",
                 $time, "found/read/count/err", got.found_position,
                 got.read_value, got.entry_count, got.error);
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.found_position !== exp.found_position) begin
        $display("%0t: found_position mismatch: expected %0d, actual %0d",
                 $time, exp.found_position, got.found_position);
        mismatches++;
      end
      if (got.read_value !== exp.read_value) begin
        $display("%0t: read_value mismatch: expected %h, actual %h",
                 $time, exp.read_value, got.read_value);
        mismatches++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, exp.entry_count, got.entry_count);
        mismatches++;
      end
      if (got.error !== exp.error) begin
        $display("%0t: error mismatch: expected %0b, actual %0b",
                 $time, exp.error, got.error);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/move_to_front_list_tb.sv =====
// Testbench top for the move-to-front list: stimulus, response monitor and run control.
module move_to_front_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtf_pkg::*;
  import mtf_list_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 10;

  logic clk;
  logic rst;

  mtf_req_if  req_if ();
  mtf_resp_if resp_if ();

  mtf_list_scoreboard sb = new();

  // Idle percentages of the two sides, changed per phase.
  int unsigned send_idle;
  int unsigned recv_idle;
  // Request for a long hold-off of the response side.
  bit          hold_start;
  // Random stimulus grows the list while set and shrinks it otherwise.
  bit          fill_mode;
  int unsigned cycle_cnt;

  move_to_front_list #(.MAX_ENTRIES(LIST_DEPTH)) u_top (
    .clk  (clk),
    .rst  (rst),
    .req  (req_if),
    .resp (resp_if)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit: a hung handshake ends the run here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("move_to_front_list_tb failed");
    $finish;
  end

  // Response side ready, with random idling and an occasional long hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    resp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        resp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        resp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Check every response transfer.
  always @(posedge clk) begin
    list_result_t got;
    if (!rst && resp_if.valid && resp_if.ready) begin
      got.found_position = resp_if.found_position;
      got.read_value     = resp_if.read_value;
      got.entry_count    = resp_if.entry_count;
      got.error          = resp_if.error;
      sb.check_result(got);
    end
  end

  // Offer one request, idling first at random, and note it once transferred.
  task automatic send_req(req_kind_t kind, logic [FIELD_W-1:0] pos,
                          logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(kind, pos, val);
  endtask

  // Stop offering and wait until every predicted response has arrived.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // A value likely to repeat, so that duplicates and search hits occur.
  function automatic logic [DATA_W-1:0] pool_value();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  // Build and send one random request shaped by the current list length.
  task automatic random_req();
    req_kind_t          kind;
    logic [FIELD_W-1:0] pos;
    logic [DATA_W-1:0]  val;
    int unsigned        cnt;
    int unsigned        roll;
    cnt  = sb.list_len();
    roll = $urandom_range(0, 99);
    if (fill_mode) begin
      if (roll < 55)      kind = REQ_INSERT;
      else if (roll < 70) kind = REQ_READ;
      else if (roll < 90) kind = REQ_SEARCH;
      else                kind = REQ_REMOVE;
    end else begin
      if (roll < 10)      kind = REQ_INSERT;
      else if (roll < 25) kind = REQ_READ;
      else if (roll < 45) kind = REQ_SEARCH;
      else                kind = REQ_REMOVE;
    end

    // Mostly legal positions, with some noise over the whole field.
    if ($urandom_range(0, 9) == 0 || kind == REQ_SEARCH) begin
      pos = FIELD_W'($urandom_range(0, 127));
    end else if (kind == REQ_INSERT) begin
      pos = FIELD_W'($urandom_range(1, cnt + 1));
    end else if (cnt > 0) begin
      pos = FIELD_W'($urandom_range(1, cnt));
    end else begin
      pos = FIELD_W'($urandom_range(0, 2));
    end

    // Search keys mostly taken from the list; insert values often repeat.
    roll = $urandom_range(0, 99);
    if (kind == REQ_SEARCH && cnt > 0 && roll < 60) begin
      val = sb.list_vals[$urandom_range(0, cnt - 1)];
    end else if (roll < 75) begin
      val = pool_value();
    end else begin
      val = $urandom();
    end

    send_req(kind, pos, val);

    // Turn around at the ends, after a few inserts into a full list.
    if (fill_mode && sb.list_len() == LIST_DEPTH && $urandom_range(0, 3) == 0)
      fill_mode = 1'b0;
    else if (!fill_mode && sb.list_len() == 0)
      fill_mode = 1'b1;
  endtask

  // One phase of random requests under the given idling.
  task automatic run_phase(int unsigned s_idle, int unsigned r_idle, bit with_hold);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_hold && i == 40) hold_start = 1'b1;
      random_req();
    end
    wait_drained();
  endtask

  // Main sequence: reset, directed requests, then three random phases.
  initial begin
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_INSERT;
    req_if.position <= '0;
    req_if.value    <= '0;
    send_idle  = 36;
    recv_idle  = 78;
    hold_start = 1'b0;
    fill_mode  = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Requests against the empty list are misses or refused.
    send_req(REQ_SEARCH, 7'd0, 32'd5);
    send_req(REQ_READ,   7'd1, 32'd0);
    send_req(REQ_REMOVE, 7'd1, 32'd0);
    send_req(REQ_INSERT, 7'd0, 32'd9);
    send_req(REQ_INSERT, 7'd2, 32'd9);

    // Build a short list with extreme values at front, middle and end.
    send_req(REQ_INSERT, 7'd1, 32'h8000_0000);
    send_req(REQ_INSERT, 7'd2, 32'h7fff_ffff);
    send_req(REQ_INSERT, 7'd1, 32'h0000_0000);
    send_req(REQ_INSERT, 7'd4, 32'hffff_ffff);
    send_req(REQ_INSERT, 7'd2, 32'd7);
    send_req(REQ_INSERT, 7'd127, 32'd1);

    // Reads in range and just past it.
    send_req(REQ_READ, 7'd1, 32'd0);
    send_req(REQ_READ, 7'd5, 32'd0);
    send_req(REQ_READ, 7'd6, 32'd0);
    send_req(REQ_READ, 7'd0, 32'd0);

    // Search hit at the front, hits deeper in the list, and a miss.
    send_req(REQ_SEARCH, 7'd0, 32'h0000_0000);
    send_req(REQ_SEARCH, 7'd64, 32'hffff_ffff);
    send_req(REQ_SEARCH, 7'd127, 32'h7fff_ffff);
    send_req(REQ_SEARCH, 7'd3, 32'd12345);

    // Removes in the middle and at the end, and refused removes.
    send_req(REQ_REMOVE, 7'd3, 32'd0);
    send_req(REQ_REMOVE, 7'd4, 32'd0);
    send_req(REQ_REMOVE, 7'd0, 32'd0);
    send_req(REQ_REMOVE, 7'd127, 32'd0);
    send_req(REQ_READ, 7'd127, 32'd0);
    wait_drained();

    run_phase(36, 78, 1'b0);
    run_phase(78, 36, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("move_to_front_list_tb passed");
    end else begin
      $display("move_to_front_list_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mtf_pkg.sv
src/mtf_req_if.sv
src/mtf_resp_if.sv
src/mtf_cell.sv
src/move_to_front_list.sv
tb/mtf_list_scoreboard_pkg.sv
tb/move_to_front_list_tb.sv
